>>> rtl/ida_pkg.sv
`timescale 1ns / 1ps

package ida_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int IDX_W = 6;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE_AT  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// per-cell controls, at most one of load/take_prev/take_next is set
	typedef struct packed {
		logic load;
		logic take_prev;
		logic take_next;
		logic sel;
	} cell_ctrl_t;

endpackage

>>> rtl/ida_req_if.sv
`timescale 1ns / 1ps

interface ida_req_if;
	logic                       valid;
	logic                       ready;
	logic [ida_pkg::OP_W-1:0]  operation;
	logic [ida_pkg::VAL_W-1:0] value;
	logic [ida_pkg::IDX_W-1:0] index;

	modport source (output valid, output operation, output value, output index, input ready);
	modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

>>> rtl/ida_rsp_if.sv
`timescale 1ns / 1ps

interface ida_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ida_pkg::VAL_W-1:0] value_res;
	logic [ida_pkg::POS_W-1:0] position;
	logic [ida_pkg::CNT_W-1:0] count;
	logic [ida_pkg::ST_W-1:0]  status;

	modport source (output valid, output value_res, output position, output count,
		output status, input ready);
	modport sink   (input valid, input value_res, input position, input count,
		input status, output ready);
endinterface

>>> rtl/ida_cell.sv
`timescale 1ns / 1ps

module ida_cell #(
	parameter int DATA_WIDTH = ida_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  ida_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] load_data,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.take_prev) begin
			data_q <= prev_data;
		end else if (ctrl.take_next) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;
	// contribution to the wired-or read bus
	assign rd   = ctrl.sel ? data_q : '0;

endmodule

>>> rtl/indexed_deque.sv
`timescale 1ns / 1ps
// channel  dir  fields
// req      in   operation, value, index
// rsp      out  value_res, position, count, status
//
// every operation, delete included, takes effect at the edge that accepts it: the cells shift in parallel
// a result is registered at the edge that accepts its transaction, req can accept every cycle unless stalled
// req.ready drops only while a result is held and rsp.ready is low
// reset clears the count and the result valid; cell contents stay undefined until written

module indexed_deque #(
	parameter int DEPTH      = ida_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ida_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ida_req_if.sink    req,
	ida_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (CW > ida_pkg::IDX_W) ? CW : ida_pkg::IDX_W;
	localparam int VW = ida_pkg::VAL_W;
	localparam int PW = ida_pkg::POS_W;
	localparam int NW = ida_pkg::CNT_W;
	localparam int SW = ida_pkg::ST_W;

	logic [CW-1:0] occ_q, occ_d;
	logic [AW-1:0] occ_ext, idx_ext, rd_pos, shift_from, pos_d;
	logic [SW-1:0] status_d;
	logic          accept, push_back_en, push_front_en, shift_en, rd_en;

	logic [DATA_WIDTH-1:0] wr_data, rd_data;
	logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd [DEPTH];

	logic          rsp_valid_q;
	logic [VW-1:0] value_res_q;
	logic [PW-1:0] position_q;
	logic [NW-1:0] count_q;
	logic [SW-1:0] status_q;

	assign accept  = req.valid && req.ready;
	assign occ_ext = AW'(occ_q);
	assign idx_ext = AW'(req.index);
	assign wr_data = DATA_WIDTH'(req.value);

	always_comb begin
		push_back_en  = 1'b0;
		push_front_en = 1'b0;
		shift_en      = 1'b0;
		rd_en         = 1'b0;
		rd_pos        = '0;
		shift_from    = '0;
		pos_d         = '0;
		status_d      = ida_pkg::ST_OK;
		occ_d         = occ_q;
		case (req.operation)
			ida_pkg::OP_PUSH_BACK: begin
				if (occ_q == CW'(DEPTH)) begin
					status_d = ida_pkg::ST_FULL;
				end else begin
					push_back_en = accept;
					pos_d        = occ_ext;
					occ_d        = occ_q + 1'b1;
				end
			end
			ida_pkg::OP_PUSH_FRONT: begin
				if (occ_q == CW'(DEPTH)) begin
					status_d = ida_pkg::ST_FULL;
				end else begin
					push_front_en = accept;
					occ_d         = occ_q + 1'b1;
				end
			end
			ida_pkg::OP_POP_BACK: begin
				if (occ_q == '0) begin
					status_d = ida_pkg::ST_EMPTY;
				end else begin
					rd_en  = 1'b1;
					rd_pos = occ_ext - 1'b1;
					pos_d  = occ_ext - 1'b1;
					occ_d  = occ_q - 1'b1;
				end
			end
			ida_pkg::OP_POP_FRONT: begin
				if (occ_q == '0) begin
					status_d = ida_pkg::ST_EMPTY;
				end else begin
					rd_en    = 1'b1;
					shift_en = accept;
					occ_d    = occ_q - 1'b1;
				end
			end
			ida_pkg::OP_READ_AT: begin
				if (idx_ext >= occ_ext) begin
					status_d = ida_pkg::ST_EMPTY;
				end else begin
					rd_en  = 1'b1;
					rd_pos = idx_ext;
					pos_d  = idx_ext;
				end
			end
			ida_pkg::OP_DELETE_AT: begin
				if (idx_ext >= occ_ext) begin
					status_d = ida_pkg::ST_EMPTY;
				end else begin
					rd_en      = 1'b1;
					rd_pos     = idx_ext;
					pos_d      = idx_ext;
					shift_en   = accept;
					shift_from = idx_ext;
					occ_d      = occ_q - 1'b1;
				end
			end
			default: begin
				status_d = ida_pkg::ST_EMPTY;
			end
		endcase
	end

	// cell g holds the element at position g from the front
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		ida_pkg::cell_ctrl_t   ctrl;
		logic [DATA_WIDTH-1:0] prev_data, next_data;

		assign ctrl.load      = push_back_en && (occ_ext == AW'(g));
		assign ctrl.take_prev = push_front_en;
		assign ctrl.take_next = shift_en && (AW'(g) >= shift_from);
		assign ctrl.sel       = rd_en && (rd_pos == AW'(g));

		if (g == 0) begin : g_first
			assign prev_data = wr_data;
		end else begin : g_mid_prev
			assign prev_data = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign next_data = cell_q[g];
		end else begin : g_mid_next
			assign next_data = cell_q[g+1];
		end

		ida_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_data (wr_data),
			.prev_data (prev_data),
			.next_data (next_data),
			.data      (cell_q[g]),
			.rd        (cell_rd[g])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_res_q <= VW'(rd_data);
			position_q  <= PW'(pos_d);
			count_q     <= NW'(occ_d);
			status_q    <= status_d;
		end
	end

	assign req.ready     = !rsp_valid_q || rsp.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_res = value_res_q;
	assign rsp.position  = position_q;
	assign rsp.count     = count_q;
	assign rsp.status    = status_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ida_pkg::ST_FULL |-> count_q == NW'(DEPTH))
		else $error("full status with store not full");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ida_pkg::ST_OK |-> value_res_q == '0 && position_q == '0)
		else $error("error result carries data");

	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push_back_en || push_front_en |=> occ_q == $past(occ_q) + 1'b1)
		else $error("push did not grow count");

	a_shift_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> occ_q == $past(occ_q) - 1'b1)
		else $error("shift did not shrink count");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [ida_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [ida_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
	localparam int unsigned PLAIN_ITEMS = 500;
	localparam int unsigned LONG_HOLD   = 48;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct {
		logic [ida_pkg::VAL_W-1:0] value_res;
		logic [ida_pkg::POS_W-1:0] position;
		logic [ida_pkg::CNT_W-1:0] count;
		logic [ida_pkg::ST_W-1:0]  status;
	} deque_reply_t;

	typedef enum {GROW, SHRINK, MIXED} traffic_t;

	// ring-buffer mirror of the store, predicts one reply per transaction
	class deque_tracker;
		logic [ida_pkg::VAL_W-1:0] slots [ida_pkg::DEPTH_DEF];
		int unsigned      front_slot;
		int unsigned      fill;
		deque_reply_t     due [$];
		int unsigned      mismatches;

		function new();
			front_slot = 0;
			fill = 0;
			mismatches = 0;
		endfunction

		function int unsigned ring(input int unsigned offset);
			return (front_slot + offset) % ida_pkg::DEPTH_DEF;
		endfunction

		function void note_request(input logic [ida_pkg::OP_W-1:0] op,
				input logic [ida_pkg::VAL_W-1:0] data, input logic [ida_pkg::IDX_W-1:0] idx);
			deque_reply_t r;
			int unsigned  i;
			r.value_res = '0;
			r.position = '0;
			r.status = ida_pkg::ST_OK;
			case (op)
				ida_pkg::OP_PUSH_BACK: begin
					if (fill >= ida_pkg::DEPTH_DEF) begin
						r.status = ida_pkg::ST_FULL;
					end else begin
						slots[ring(fill)] = data;
						r.position = ida_pkg::POS_W'(fill);
						fill++;
					end
				end
				ida_pkg::OP_PUSH_FRONT: begin
					if (fill >= ida_pkg::DEPTH_DEF) begin
						r.status = ida_pkg::ST_FULL;
					end else begin
						front_slot = (front_slot + ida_pkg::DEPTH_DEF - 1) % ida_pkg::DEPTH_DEF;
						slots[front_slot] = data;
						fill++;
					end
				end
				ida_pkg::OP_POP_BACK: begin
					if (fill == 0) begin
						r.status = ida_pkg::ST_EMPTY;
					end else begin
						fill--;
						r.value_res = slots[ring(fill)];
						r.position = ida_pkg::POS_W'(fill);
					end
				end
				ida_pkg::OP_POP_FRONT: begin
					if (fill == 0) begin
						r.status = ida_pkg::ST_EMPTY;
					end else begin
						r.value_res = slots[front_slot];
						front_slot = (front_slot + 1) % ida_pkg::DEPTH_DEF;
						fill--;
					end
				end
				ida_pkg::OP_READ_AT: begin
					if (idx >= fill) begin
						r.status = ida_pkg::ST_EMPTY;
					end else begin
						r.value_res = slots[ring(idx)];
						r.position = idx;
					end
				end
				ida_pkg::OP_DELETE_AT: begin
					if (idx >= fill) begin
						r.status = ida_pkg::ST_EMPTY;
					end else begin
						r.value_res = slots[ring(idx)];
						// later elements move one place toward the front
						for (i = idx; i + 1 < fill; i++)
							slots[ring(i)] = slots[ring(i + 1)];
						fill--;
						r.position = idx;
					end
				end
				default: begin
					r.status = ida_pkg::ST_EMPTY;
				end
			endcase
			r.count = ida_pkg::CNT_W'(fill);
			due.push_back(r);
		endfunction

		function void check_reply(input deque_reply_t got);
			deque_reply_t exp_r;
			if (due.size() == 0) begin
				$display("%0t: reply expected none actual value_res %h count %0d status %0d",
					$time, got.value_res, got.count, got.status);
				mismatches++;
				return;
			end
			exp_r = due.pop_front();
			if (got.value_res !== exp_r.value_res) begin
				$display("%0t: value_res expected %h actual %h", $time, exp_r.value_res,
					got.value_res);
				mismatches++;
			end
			if (got.position !== exp_r.position) begin
				$display("%0t: position expected %0d actual %0d", $time, exp_r.position,
					got.position);
				mismatches++;
			end
			if (got.count !== exp_r.count) begin
				$display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
				mismatches++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
					got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ida_req_if req_ch ();
	ida_rsp_if rsp_ch ();

	indexed_deque u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_tracker tracker = new();
	bit           quiet_phase;
	bit           long_hold_req;
	int unsigned  cycle_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		deque_reply_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.value_res = rsp_ch.value_res;
			got.position = rsp_ch.position;
			got.count = rsp_ch.count;
			got.status = rsp_ch.status;
			tracker.check_reply(got);
		end
	end

	// receiver side: random stall bursts, plus one long hold-off on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet_phase && $urandom_range(0, 99) < 12) begin
				stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic [ida_pkg::OP_W-1:0] op,
			input logic [ida_pkg::VAL_W-1:0] data, input logic [ida_pkg::IDX_W-1:0] idx);
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.value <= data;
		req_ch.index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(op, data, idx);
		if (!quiet_phase && $urandom_range(0, 99) < 15) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic idle_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.due.size() != 0);
	endtask

	function automatic logic [ida_pkg::OP_W-1:0] pick_op(input traffic_t mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mode)
			GROW: begin
				if (r < 40) return ida_pkg::OP_PUSH_BACK;
				if (r < 75) return ida_pkg::OP_PUSH_FRONT;
				if (r < 80) return ida_pkg::OP_POP_BACK;
				if (r < 85) return ida_pkg::OP_POP_FRONT;
				if (r < 93) return ida_pkg::OP_READ_AT;
				if (r < 98) return ida_pkg::OP_DELETE_AT;
			end
			SHRINK: begin
				if (r < 5) return ida_pkg::OP_PUSH_BACK;
				if (r < 10) return ida_pkg::OP_PUSH_FRONT;
				if (r < 35) return ida_pkg::OP_POP_BACK;
				if (r < 60) return ida_pkg::OP_POP_FRONT;
				if (r < 70) return ida_pkg::OP_READ_AT;
				if (r < 98) return ida_pkg::OP_DELETE_AT;
			end
			default: begin
				if (r < 16) return ida_pkg::OP_PUSH_BACK;
				if (r < 32) return ida_pkg::OP_PUSH_FRONT;
				if (r < 48) return ida_pkg::OP_POP_BACK;
				if (r < 64) return ida_pkg::OP_POP_FRONT;
				if (r < 80) return ida_pkg::OP_READ_AT;
				if (r < 96) return ida_pkg::OP_DELETE_AT;
			end
		endcase
		return (r % 2 == 0) ? OP_RSVD_6 : OP_RSVD_7;
	endfunction

	function automatic logic [ida_pkg::IDX_W-1:0] pick_index();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (tracker.fill == 0 || r < 2)
			return ida_pkg::IDX_W'($urandom_range(0, 63));
		if (r < 3)
			return ida_pkg::IDX_W'(tracker.fill);
		if (r < 5)
			return ida_pkg::IDX_W'(tracker.fill - 1);
		return ida_pkg::IDX_W'($urandom_range(0, tracker.fill - 1));
	endfunction

	function automatic logic [ida_pkg::VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	initial begin
		logic [ida_pkg::OP_W-1:0] op;
		traffic_t        mode;
		int unsigned     plain_count;
		int unsigned     in_mode;
		bit              hold_done;
		bit              pause_done;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = ida_pkg::OP_PUSH_BACK;
		req_ch.value = '0;
		req_ch.index = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, reserved codes, then a short list covering each end
		send_request(ida_pkg::OP_POP_BACK, '0, '0);
		send_request(ida_pkg::OP_POP_FRONT, '0, '0);
		send_request(ida_pkg::OP_READ_AT, '0, '0);
		send_request(ida_pkg::OP_DELETE_AT, '1, '0);
		send_request(OP_RSVD_6, '1, '1);
		send_request(OP_RSVD_7, '0, '0);
		send_request(ida_pkg::OP_PUSH_BACK, 32'h0000_0000, '0);
		send_request(ida_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, '1);
		send_request(ida_pkg::OP_PUSH_FRONT, 32'h8000_0001, '0);
		send_request(ida_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFE, '0);
		send_request(ida_pkg::OP_READ_AT, '0, 6'd0);
		send_request(ida_pkg::OP_READ_AT, '0, 6'd3);
		send_request(ida_pkg::OP_READ_AT, '0, 6'd4);
		send_request(ida_pkg::OP_READ_AT, '0, 6'd63);
		send_request(ida_pkg::OP_DELETE_AT, '0, 6'd63);
		send_request(ida_pkg::OP_DELETE_AT, '0, 6'd1);
		send_request(ida_pkg::OP_DELETE_AT, '0, 6'd2);
		send_request(ida_pkg::OP_DELETE_AT, '0, 6'd0);
		send_request(ida_pkg::OP_PUSH_BACK, 32'hAAAA_5555, '0);
		send_request(ida_pkg::OP_POP_FRONT, '0, '0);
		send_request(ida_pkg::OP_POP_BACK, '0, '0);
		send_request(ida_pkg::OP_POP_BACK, '0, '0);
		idle_until_drained();

		// alternate fill-up, drain and mixed traffic so the full and empty ends recur
		mode = GROW;
		plain_count = 0;
		in_mode = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (plain_count < PLAIN_ITEMS) begin
			if (plain_count >= 150 && !hold_done) begin
				hold_done = 1'b1;
				long_hold_req = 1'b1;
			end
			if (plain_count >= 300 && !pause_done) begin
				pause_done = 1'b1;
				idle_until_drained();
			end
			if (plain_count >= PLAIN_ITEMS - 100)
				quiet_phase = 1'b1;
			op = pick_op(mode);
			if (op <= ida_pkg::OP_DELETE_AT)
				plain_count++;
			send_request(op, pick_value(), pick_index());
			case (mode)
				GROW: begin
					if (tracker.fill == ida_pkg::DEPTH_DEF)
						in_mode++;
					if (in_mode > 8) begin
						mode = SHRINK;
						in_mode = 0;
					end
				end
				SHRINK: begin
					if (tracker.fill == 0)
						in_mode++;
					if (in_mode > 4) begin
						mode = MIXED;
						in_mode = 0;
					end
				end
				default: begin
					in_mode++;
					if (in_mode > 40) begin
						mode = GROW;
						in_mode = 0;
					end
				end
			endcase
		end

		idle_until_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> indexed_deque.f
rtl/ida_pkg.sv
rtl/ida_req_if.sv
rtl/ida_rsp_if.sv
rtl/ida_cell.sv
rtl/indexed_deque.sv
bench/tb_top.sv
